// ----- hw/rtl/cot_pkg.sv -----
package cot_pkg;

	localparam int CAPACITY_DEF = 16;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_LOOKUP = 2'd1,
		FN_DELETE = 2'd2,
		FN_REMOVE = 2'd3
	} cot_func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} cot_status_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] owner;
		logic [31:0] region_size;
	} cot_entry_t;

endpackage

// ----- hw/rtl/cot_ram.sv -----
module cot_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  cot_pkg::cot_entry_t wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output cot_pkg::cot_entry_t rdata
);
	import cot_pkg::*;

	cot_entry_t mem [DEPTH];

	// one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/compacting_owner_table_top.sv -----
// Compacting owner table.
// Input channel (in_valid / in_stall) carries one command beat: func, handle,
// owner, region_size. Output channel (out_valid / out_stall) returns exactly
// one result beat per command: index, hit, status, entry_count, removed_count.
// Entries live packed in slots 0 .. count-1 of a single one-read, one-write
// synchronous RAM; no hole is ever left.
// An insert goes straight to the done state; its result is loaded into the
// output register once that register is free. Lookup, delete and
// remove-by-owner sweep every valid slot once through the RAM read port, one
// slot per cycle, writing survivors back to their compacted slot on the write
// port as the read data returns; the result is loaded once the sweep ends and
// the output register is free. The next command is taken in the cycle after
// the result is loaded. Commands are taken one at a time; in_stall is high
// while one is in progress.
// A finished result sits in the output register; a new command is accepted
// while it waits, but that command's own result is held back until the
// receiver takes the earlier beat. A stalled beat stays unchanged.
// Reset sets the entry count to zero and empties the output register. The RAM
// is not cleared: only slots below the count are ever read, and each of them
// has been written.
module compacting_owner_table_top #(
	parameter int CAPACITY = cot_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] handle,
	input  logic [15:0] owner,
	input  logic [31:0] region_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  index,
	output logic        hit,
	output logic [1:0]  status,
	output logic [8:0]  entry_count,
	output logic [8:0]  removed_count
);
	import cot_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;     // valid entries
	logic [CNT_W-1:0]   rd_q;      // next slot to read
	logic [CNT_W-1:0]   wr_q;      // next compacted slot to write
	logic [CNT_W-1:0]   rm_q;      // entries dropped so far
	logic               found_q;
	logic [IDX_W-1:0]   pos_q;
	cot_func_t          func_q;
	logic [31:0]        handle_q;
	logic [15:0]        owner_q;
	logic [31:0]        size_q;

	// read pipeline: slot whose data comes back this cycle
	logic               vld_s1;

	logic               out_valid_q;
	logic [7:0]         index_q;
	logic               hit_q;
	logic [1:0]         status_q;
	logic [8:0]         entry_count_q;
	logic [8:0]         removed_count_q;

	cot_entry_t         rdata;
	cot_entry_t         wdata;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic               ram_re;

	logic               out_free;
	logic               is_full;
	logic               match_h;
	logic               drop;
	logic               first_hit;
	logic               compacting;
	logic               scan_done;
	logic [CNT_W-1:0]   new_cnt;
	logic [7:0]         res_index;
	logic               res_hit;
	cot_status_t        res_status;
	logic [CNT_W-1:0]   res_removed;

	assign out_free   = !out_valid_q || !out_stall;
	assign is_full    = (cnt_q == CAP_C);
	assign compacting = (func_q == FN_DELETE) || (func_q == FN_REMOVE);
	assign ram_re     = (state_q == S_SCAN) && (rd_q < cnt_q);
	assign scan_done  = (state_q == S_SCAN) && !ram_re && !vld_s1;

	// compare returning slot; only the lowest handle match counts
	always_comb begin
		match_h   = (rdata.handle == handle_q);
		first_hit = vld_s1 && !found_q && match_h &&
		            ((func_q == FN_LOOKUP) || (func_q == FN_DELETE));
		drop      = vld_s1 && (((func_q == FN_DELETE) && first_hit) ||
		            ((func_q == FN_REMOVE) && (rdata.owner == owner_q)));
	end

	// write port: insert append, or survivor moved down during a sweep.
	// Writes always land at or below the slot just read, so never on a slot
	// still to be read.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[IDX_W-1:0];
		wdata     = rdata;
		if (state_q == S_DONE && func_q == FN_INSERT && out_free && !is_full) begin
			ram_we      = 1'b1;
			ram_waddr   = cnt_q[IDX_W-1:0];
			wdata       = '{handle: handle_q, owner: owner_q, region_size: size_q};
		end else if (vld_s1 && compacting && !drop) begin
			ram_we = 1'b1;
		end
	end

	// result of the finished command
	always_comb begin
		res_index   = 8'd0;
		res_hit     = 1'b0;
		res_status  = ST_NOT_FOUND;
		res_removed = rm_q;
		new_cnt     = cnt_q - rm_q;
		case (func_q)
			FN_INSERT: begin
				res_removed = '0;
				if (is_full) begin
					res_status = ST_FULL;
				end else begin
					res_index  = 8'(cnt_q);
					res_hit    = 1'b1;
					res_status = ST_OK;
					new_cnt    = cnt_q + CNT_W'(1);
				end
			end
			FN_REMOVE: begin
				if (rm_q != '0) begin
					res_hit    = 1'b1;
					res_status = ST_OK;
				end
			end
			default: begin
				if (found_q) begin
					res_index  = 8'(pos_q);
					res_hit    = 1'b1;
					res_status = ST_OK;
				end
			end
		endcase
	end

	cot_ram #(
		.DEPTH (CAPACITY),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			rm_q        <= '0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished result, else retire the beat once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q   <= cot_func_t'(func);
						handle_q <= handle;
						owner_q  <= owner;
						size_q   <= region_size;
						rd_q     <= '0;
						wr_q     <= '0;
						rm_q     <= '0;
						found_q  <= 1'b0;
						pos_q    <= '0;
						vld_s1   <= 1'b0;
						state_q  <= (cot_func_t'(func) == FN_INSERT) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= ram_re;
					if (ram_re) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (first_hit) begin
						found_q <= 1'b1;
						pos_q   <= rd_q[IDX_W-1:0] - IDX_W'(1);
					end
					if (drop) begin
						rm_q <= rm_q + CNT_W'(1);
					end else if (vld_s1 && compacting) begin
						wr_q <= wr_q + CNT_W'(1);
					end
					if (scan_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						index_q         <= res_index;
						hit_q           <= res_hit;
						status_q        <= res_status;
						entry_count_q   <= 9'(new_cnt);
						removed_count_q <= 9'(res_removed);
						cnt_q           <= new_cnt;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign index         = index_q;
	assign hit           = hit_q;
	assign status        = status_q;
	assign entry_count   = entry_count_q;
	assign removed_count = removed_count_q;

endmodule

// ----- hw/rtl/cot_checker.sv -----
module cot_checker #(
	parameter int CAPACITY = cot_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  index,
	input logic        hit,
	input logic [1:0]  status,
	input logic [8:0]  entry_count,
	input logic [8:0]  removed_count
);
	import cot_pkg::*;

	localparam logic [8:0] CAP_C = 9'(CAPACITY);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(index) && $stable(hit) &&
		$stable(status) && $stable(entry_count) && $stable(removed_count))
		else $error("stalled result beat changed");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (status == ST_OK)))
		else $error("hit disagrees with status");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> index == 8'd0 && removed_count == 9'd0)
		else $error("miss with non-zero index or removed count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == CAP_C)
		else $error("full reported below capacity");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CAP_C && removed_count <= CAP_C)
		else $error("count beyond capacity");

endmodule

bind compacting_owner_table_top cot_checker #(
	.CAPACITY (CAPACITY)
) u_cot_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.index         (index),
	.hit           (hit),
	.status        (status),
	.entry_count   (entry_count),
	.removed_count (removed_count)
);
